[design/pdx_pkg.sv]
// pdx_pkg: shared constants, key table and result word type for the packet deframer
// no dependencies; imported by pdx_out_reg and packet_deframer_xor_decoder
`timescale 1ns / 1ps

package pdx_pkg;

  // packet size bound; accepted lengths run up to MaxPacket-1
  localparam int unsigned MaxPacket = 2048;
  localparam int unsigned LenW      = $clog2(MaxPacket);
  localparam logic [16:0] MaxLen    = 17'(MaxPacket - 1);

  localparam logic [7:0] HdrShort = 8'hC1;
  localparam logic [7:0] HdrLong  = 8'hC2;

  localparam logic [LenW-1:0] HdrSizeShort = LenW'(2);
  localparam logic [LenW-1:0] HdrSizeLong  = LenW'(3);

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadHdr = 2'd1;
  localparam logic [1:0] StatusBadLen = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       first;
    logic       last;
    logic [1:0] status;
  } result_t;

  function automatic logic [7:0] key_byte(input logic [4:0] idx);
    logic [7:0] k;
    case (idx)
      5'd0:  k = 8'hE7;
      5'd1:  k = 8'h6D;
      5'd2:  k = 8'h3A;
      5'd3:  k = 8'h89;
      5'd4:  k = 8'hBC;
      5'd5:  k = 8'hB2;
      5'd6:  k = 8'h9F;
      5'd7:  k = 8'h73;
      5'd8:  k = 8'h23;
      5'd9:  k = 8'hA8;
      5'd10: k = 8'hFE;
      5'd11: k = 8'hB6;
      5'd12: k = 8'h49;
      5'd13: k = 8'h5D;
      5'd14: k = 8'h39;
      5'd15: k = 8'h5D;
      5'd16: k = 8'h8A;
      5'd17: k = 8'hCB;
      5'd18: k = 8'h63;
      5'd19: k = 8'h8D;
      5'd20: k = 8'hEA;
      5'd21: k = 8'h7D;
      5'd22: k = 8'h2B;
      5'd23: k = 8'h5F;
      5'd24: k = 8'hC3;
      5'd25: k = 8'hB1;
      5'd26: k = 8'hE9;
      5'd27: k = 8'h83;
      5'd28: k = 8'h29;
      5'd29: k = 8'h51;
      5'd30: k = 8'hE8;
      default: k = 8'h56;
    endcase
    return k;
  endfunction

endpackage

[design/pdx_out_reg.sv]
// pdx_out_reg: result register with valid/ready toward the downstream side
// depends on pdx_pkg for the result word type
`timescale 1ns / 1ps

module pdx_out_reg
  import pdx_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  result_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // a new word may load while the held one is taken in the same cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_d = valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/packet_deframer_xor_decoder.sv]
// packet_deframer_xor_decoder: header parser and chained xor decoder, top level
// depends on pdx_pkg and pdx_out_reg
`timescale 1ns / 1ps

// Usage:
// - input channel: data_byte_i with in_valid_i / in_ready_o, one raw stream
//   byte per accepted word
// - output channel: out_byte_o, first_of_packet_o, last_of_packet_o and
//   frame_status_o with out_valid_o / out_ready_i, exactly one result word
//   for every accepted input word, in order
// - the result word is registered: a byte accepted at a clock edge is presented at the
//   output after that edge
// - one byte per cycle while the receiver keeps up; parsing and decoding of a byte is a
//   single pass of logic from the byte and the parser state into the
//   result register
// - when the receiver stalls, the result register holds its word and
//   in_ready_o drops until it is taken; a word can be loaded in the same
//   cycle the held one leaves
// - reset (rst_ni low, asynchronous) empties the result register and puts
//   the parser back to waiting for a header byte
// - bytes that are not a header while waiting come out raw with a bad
//   header status; a bad length drops the frame and parsing resyncs

module packet_deframer_xor_decoder
  import pdx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       first_of_packet_o,
  output logic       last_of_packet_o,
  output logic [1:0] frame_status_o
);

  localparam logic [1:0] PhWait = 2'd0;
  localparam logic [1:0] PhLen1 = 2'd1;
  localparam logic [1:0] PhLen2 = 2'd2;
  localparam logic [1:0] PhBody = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic            long_q, long_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [7:0]      prev_q, prev_d;

  logic            accept;
  result_t         res;
  result_t         res_out;

  logic [16:0]     fin_len;
  logic [LenW-1:0] fin_hdr;
  logic            fin_bad;
  logic            fin_last;
  logic [LenW-1:0] body_hdr;
  logic [LenW:0]   pos_inc;
  logic            body_last;
  logic [7:0]      body_byte;

  assign accept = in_valid_i && in_ready_o;

  // length judged on the last length byte of either header kind
  always_comb begin
    if (phase_q == PhLen2) begin
      fin_len = {1'b0, len_hi_q, data_byte_i};
      fin_hdr = HdrSizeLong;
    end else begin
      fin_len = {9'd0, data_byte_i};
      fin_hdr = HdrSizeShort;
    end
    fin_bad  = (fin_len < 17'(fin_hdr)) || (fin_len > MaxLen);
    fin_last = (fin_len == 17'(fin_hdr));
  end

  always_comb begin
    body_hdr  = long_q ? HdrSizeLong : HdrSizeShort;
    pos_inc   = {1'b0, pos_q} + (LenW + 1)'(1);
    body_last = (pos_inc >= {1'b0, len_q});
    // byte just after the header passes raw
    if (pos_q <= body_hdr) begin
      body_byte = data_byte_i;
    end else begin
      body_byte = data_byte_i ^ prev_q ^ key_byte(pos_q[4:0]);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    long_d   = long_q;
    len_hi_d = len_hi_q;
    len_d    = len_q;
    pos_d    = pos_q;
    prev_d   = prev_q;

    res.out_byte = data_byte_i;
    res.first    = 1'b0;
    res.last     = 1'b0;
    res.status   = StatusOk;

    unique case (phase_q)
      PhWait: begin
        if (data_byte_i == HdrShort || data_byte_i == HdrLong) begin
          long_d    = (data_byte_i == HdrLong);
          pos_d     = LenW'(1);
          prev_d    = data_byte_i;
          phase_d   = PhLen1;
          res.first = 1'b1;
        end else begin
          res.status = StatusBadHdr;
        end
      end
      PhLen1, PhLen2: begin
        if (phase_q == PhLen1 && long_q) begin
          len_hi_d = data_byte_i;
          pos_d    = LenW'(2);
          prev_d   = data_byte_i;
          phase_d  = PhLen2;
        end else if (fin_bad) begin
          res.status = StatusBadLen;
          phase_d    = PhWait;
        end else begin
          res.last = fin_last;
          len_d    = fin_len[LenW-1:0];
          prev_d   = data_byte_i;
          pos_d    = fin_hdr;
          phase_d  = fin_last ? PhWait : PhBody;
        end
      end
      default: begin
        res.out_byte = body_byte;
        res.last     = body_last;
        prev_d       = body_byte;
        pos_d        = pos_inc[LenW-1:0];
        if (body_last) begin
          phase_d = PhWait;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhWait;
      long_q   <= 1'b0;
      len_hi_q <= 8'd0;
      len_q    <= '0;
      pos_q    <= '0;
      prev_q   <= 8'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      long_q   <= long_d;
      len_hi_q <= len_hi_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      prev_q   <= prev_d;
    end
  end

  pdx_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_out)
  );

  assign out_byte_o        = res_out.out_byte;
  assign first_of_packet_o = res_out.first;
  assign last_of_packet_o  = res_out.last;
  assign frame_status_o    = res_out.status;

endmodule
